// ----- rtl/qwspwm_pkg.sv -----
// ============================================================================
// qwspwm_pkg - shared types and constants of the quarter-wave SPWM sequencer
// Holds the field widths, register indexes, CORDIC constants and the
// sequencer state type.
// ============================================================================
package qwspwm_pkg;

  // Field widths of the configuration and result words.
  localparam int FREQ_W = 10;
  localparam int AMP_W  = 7;
  localparam int CMP_W  = 9;
  localparam int QTR_W  = 2;

  // Configuration register indexes.
  localparam logic REG_FREQ_HZ       = 1'b0;
  localparam logic REG_AMPLITUDE_PCT = 1'b1;

  // Accepted configuration ranges and reset values.
  localparam int FREQ_MIN   = 100;
  localparam int FREQ_MAX   = 1000;
  localparam int FREQ_RESET = 100;
  localparam int AMP_MAX    = 99;

  // Phase scale: 65536 stands for a quarter turn.
  localparam int PHASE_FRAC = 16;
  localparam int PHASE_W    = PHASE_FRAC + 1;

  // CORDIC datapath.
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CORDIC_XW    = 18;
  localparam int CORDIC_ZW    = 19;
  localparam int CORDIC_X0    = 19899;
  localparam int SINE_W       = 16;
  localparam int SINE_FULL    = 32768;

  localparam logic [15:0] ATAN_TABLE [CORDIC_STEPS] = '{
    16'd32768, 16'd19344, 16'd10221, 16'd5188, 16'd2604, 16'd1303, 16'd652, 16'd326,
    16'd163,   16'd81,    16'd41,    16'd20,   16'd10,   16'd5,    16'd3,   16'd1
  };

  // Amplitude scaling: sample = floor(amp * 18 * sine / 2^15 / 5).
  localparam int AMP18_W     = 11;
  localparam int PROD_W      = AMP18_W + SINE_W;
  localparam int Q15_SHIFT   = 15;
  localparam int T_W         = PROD_W - Q15_SHIFT;
  localparam int DIV5_RECIP  = 13108;
  localparam int DIV5_SHIFT  = 16;
  localparam int RECIP_W     = 14;
  localparam int SCALED_W    = T_W + RECIP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NDIV,
    ST_PDIV,
    ST_CORDIC,
    ST_MUL,
    ST_SCALE,
    ST_OUT
  } seq_state_t;

endpackage

// ----- rtl/qwspwm_divider.sv -----
// ============================================================================
// qwspwm_divider - shared restoring divider
// Produces one quotient bit per cycle; serves both the points-per-quarter
// computation and the phase computation.
// ============================================================================
module qwspwm_divider #(
  parameter int DW = 24,
  parameter int VW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dsr;
  logic [DW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem, quo[DW-1]};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? VW'(trial - {1'b0, dsr}) : trial[VW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ----- rtl/qwspwm_cordic.sv -----
// ============================================================================
// qwspwm_cordic - iterative rotation-mode CORDIC sine
// One micro-rotation per cycle over sixteen steps; result clamped to the
// Q1.15 range 0 to 1.0.
// ============================================================================
module qwspwm_cordic import qwspwm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PHASE_W-1:0] phase,
  output logic               done,
  output logic [SINE_W-1:0]  sine
);

  logic signed [CORDIC_XW-1:0] x;
  logic signed [CORDIC_XW-1:0] y;
  logic signed [CORDIC_XW-1:0] dx;
  logic signed [CORDIC_XW-1:0] dy;
  logic signed [CORDIC_ZW-1:0] z;
  logic signed [CORDIC_ZW-1:0] ang;
  logic [STEP_W-1:0]           step;
  logic                        busy;

  // Arithmetic right shifts floor negative values, as the sine scale expects.
  assign dx  = y >>> step;
  assign dy  = x >>> step;
  assign ang = signed'(CORDIC_ZW'(ATAN_TABLE[step]));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CORDIC_XW'(CORDIC_X0);
      y <= '0;
      z <= signed'(CORDIC_ZW'(phase));
    end else if (busy) begin
      if (!z[CORDIC_ZW-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - ang;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + ang;
      end
    end
  end

  always_comb begin
    if (y[CORDIC_XW-1]) begin
      sine = '0;
    end else if (y > signed'(CORDIC_XW'(SINE_FULL))) begin
      sine = SINE_W'(SINE_FULL);
    end else begin
      sine = y[SINE_W-1:0];
    end
  end

endmodule

// ----- rtl/quarter_wave_spwm_sequencer_unit.sv -----
// ============================================================================
// quarter_wave_spwm_sequencer_unit - quarter-wave sine PWM compare sequencer
// Steps a four-quarter sine PWM sequence by one point per timer tick and
// returns the compare values of both half-bridge channels.
// ============================================================================
// Each input word carries one update_event flag and yields exactly one result
// word. A word with update_event set computes the next sine point: the phase
// k/N is formed in a shared bit-serial divider, the sine comes from a
// sixteen-step CORDIC, and two registered multiplies scale it by
// amplitude_pct*360/100. Such a word presents its result once the divider,
// the CORDIC loop and both multiplies have run in turn; a word without the
// tick presents the held compares in the cycle right after acceptance. The
// block handles one word at a time: in_ready is low from acceptance until
// the result word has been taken. Writing freq_hz while idle starts a
// points-per-quarter division during which no input word is accepted; a
// freq_hz write in the same cycle as an offered input word takes precedence.
// Writes outside the legal ranges are ignored. Channel A (high_side_compare)
// carries the first half-wave and channel B (low_side_compare) the second;
// quarter reports the quarter as it stood before the word was applied.
// ============================================================================
module quarter_wave_spwm_sequencer_unit import qwspwm_pkg::*; #(
  parameter int TICK_RATE_HZ       = 40000,
  parameter int MAX_QUARTER_POINTS = 128
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration write port.
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [FREQ_W-1:0] cfg_data,
  // Input channel.
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              update_event,
  // Result channel.
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CMP_W-1:0]  high_side_compare,
  output logic [CMP_W-1:0]  low_side_compare,
  output logic [QTR_W-1:0]  quarter
);

  // Point counters and N hold values up to MAX_QUARTER_POINTS.
  localparam int PW      = $clog2(MAX_QUARTER_POINTS + 1);
  localparam int TW      = $clog2(TICK_RATE_HZ + 1);
  localparam int DW      = (PW + PHASE_FRAC > TW) ? PW + PHASE_FRAC : TW;
  localparam int VW      = (PW > FREQ_W) ? PW : FREQ_W;
  localparam int RAW_N   = (TICK_RATE_HZ / FREQ_RESET) / 4;
  localparam int RESET_N = (RAW_N > MAX_QUARTER_POINTS) ? MAX_QUARTER_POINTS :
                           ((RAW_N < 1) ? 1 : RAW_N);

  seq_state_t state;
  seq_state_t state_next;

  // Sequence state.
  logic [QTR_W-1:0]  quarter_index;
  logic [PW-1:0]     point_index;
  logic [PW-1:0]     points_per_quarter;
  logic [CMP_W-1:0]  held_high_compare;
  logic [CMP_W-1:0]  held_low_compare;
  logic [AMP_W-1:0]  amplitude_pct;

  // Per-word working registers.
  logic [QTR_W-1:0]  q_hold;
  logic [PW-1:0]     j_hold;
  logic [PROD_W-1:0] prod;
  logic [CMP_W-1:0]  sample;

  // Decoded configuration writes.
  logic freq_write;
  logic amp_write;

  // Point selection.
  logic [PW-1:0] j_sel;
  logic [PW-1:0] k_sel;

  // Shared divider and CORDIC hookup.
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [VW-1:0] div_divisor;
  logic          div_done;
  logic [DW-1:0] div_quotient;
  logic          cordic_start;
  logic          cordic_done;
  logic [SINE_W-1:0] sine;

  // Scaling and N clamp.
  logic [AMP18_W-1:0]  amp18;
  logic [T_W-1:0]      prod_t;
  logic [SCALED_W-1:0] scaled;
  logic [DW-3:0]       n_raw;
  logic [PW-1:0]       n_new;
  logic                in_accept;
  logic                last_point;

  assign freq_write = cfg_write && (cfg_index == REG_FREQ_HZ) &&
                      (cfg_data >= FREQ_W'(FREQ_MIN)) && (cfg_data <= FREQ_W'(FREQ_MAX));
  assign amp_write  = cfg_write && (cfg_index == REG_AMPLITUDE_PCT) &&
                      (cfg_data <= FREQ_W'(AMP_MAX));

  assign in_ready  = (state == ST_IDLE) && !freq_write;
  assign in_accept = in_valid && in_ready;
  assign out_valid = (state == ST_OUT);

  // After a frequency change the point index may sit past the new N; the
  // tick then plays the last point of the quarter.
  assign j_sel = (point_index >= points_per_quarter) ? points_per_quarter - 1'b1
                                                     : point_index;
  // Odd quarters run the sine backward from N down to 1.
  assign k_sel = quarter_index[0] ? points_per_quarter - j_sel : j_sel;

  assign div_dividend = freq_write ? DW'(TICK_RATE_HZ) : DW'({k_sel, {PHASE_FRAC{1'b0}}});
  assign div_divisor  = freq_write ? VW'(cfg_data) : VW'(points_per_quarter);

  // N = floor(floor(tick/f)/4), held to the range 1..MAX_QUARTER_POINTS.
  assign n_raw = div_quotient[DW-1:2];
  always_comb begin
    if (n_raw > (DW-2)'(MAX_QUARTER_POINTS)) begin
      n_new = PW'(MAX_QUARTER_POINTS);
    end else if (n_raw == '0) begin
      n_new = PW'(1);
    end else begin
      n_new = n_raw[PW-1:0];
    end
  end

  // amp*18 by shift and add; division by 5 as a reciprocal multiply.
  assign amp18  = {amplitude_pct, 4'b0} + AMP18_W'({amplitude_pct, 1'b0});
  assign prod_t = prod[PROD_W-1:Q15_SHIFT];
  assign scaled = prod_t * RECIP_W'(DIV5_RECIP);
  assign sample = scaled[DIV5_SHIFT +: CMP_W];

  assign last_point = ({1'b0, j_hold} + 1'b1) >= {1'b0, points_per_quarter};

  qwspwm_divider #(
    .DW (DW),
    .VW (VW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  qwspwm_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .phase (div_quotient[PHASE_W-1:0]),
    .done  (cordic_done),
    .sine  (sine)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    cordic_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (freq_write) begin
          div_start  = 1'b1;
          state_next = ST_NDIV;
        end else if (in_valid) begin
          if (update_event) begin
            div_start  = 1'b1;
            state_next = ST_PDIV;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_NDIV: begin
        // A second frequency write restarts the division.
        if (freq_write) begin
          div_start = 1'b1;
        end else if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_PDIV: begin
        if (div_done) begin
          cordic_start = 1'b1;
          state_next   = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (cordic_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control and sequence state.
  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_index      <= '0;
      point_index        <= '0;
      points_per_quarter <= PW'(RESET_N);
      held_high_compare  <= '0;
      held_low_compare   <= '0;
      amplitude_pct      <= '0;
    end else begin
      if (amp_write) begin
        amplitude_pct <= cfg_data[AMP_W-1:0];
      end
      if ((state == ST_NDIV) && div_done && !freq_write) begin
        points_per_quarter <= n_new;
      end
      if (state == ST_SCALE) begin
        if (!q_hold[1]) begin
          held_high_compare <= sample;
          held_low_compare  <= '0;
        end else begin
          held_high_compare <= '0;
          held_low_compare  <= sample;
        end
        if (last_point) begin
          point_index   <= '0;
          quarter_index <= q_hold + 1'b1;
        end else begin
          point_index <= j_hold + 1'b1;
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_hold <= quarter_index;
      j_hold <= j_sel;
    end
    if (state == ST_MUL) begin
      prod <= amp18 * sine;
    end
  end

  assign high_side_compare = held_high_compare;
  assign low_side_compare  = held_low_compare;
  assign quarter           = q_hold;

`ifndef SYNTHESIS
  // Only one channel carries a nonzero compare at a time.
  a_one_channel: assert property (@(posedge clk) disable iff (rst)
    !((held_high_compare != '0) && (held_low_compare != '0)))
    else $error("both channels hold nonzero compares");

  // N always stays within 1..MAX_QUARTER_POINTS.
  a_n_range: assert property (@(posedge clk) disable iff (rst)
    (points_per_quarter != '0) && (points_per_quarter <= PW'(MAX_QUARTER_POINTS)))
    else $error("points per quarter out of range");

  // The scaled sample never exceeds the 99 percent peak.
  a_cmp_range: assert property (@(posedge clk) disable iff (rst)
    (held_high_compare <= CMP_W'(356)) && (held_low_compare <= CMP_W'(356)))
    else $error("compare value above peak");

  // No new word is taken while a result waits.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  // The sequence only advances on a computed tick.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ($past(state) != ST_SCALE) && !$past(rst) |-> $stable(quarter_index))
    else $error("quarter changed outside a tick update");
`endif

endmodule
